FILE: rtl/core/pid_integral_zone_antiwindup_defines.svh
// Assertion helpers for the heading-hold PID block.
`ifndef PID_INTEGRAL_ZONE_ANTIWINDUP_DEFINES_SVH
`define PID_INTEGRAL_ZONE_ANTIWINDUP_DEFINES_SVH

`ifndef SYNTHESIS
`define PIDZ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidz assertion failed");
`define PIDZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidz assertion failed");
`else
`define PIDZ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PIDZ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/pidz_pkg.sv
`timescale 1ns / 1ps

package pidz_pkg;

    // field and register widths
    localparam int ERR_W      = 24;
    localparam int DT_W       = 8;
    localparam int YAW_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int ZONE_W     = 23;
    localparam int ILIM_W     = 39;
    localparam int OLIM_W     = 15;
    localparam int CMD_W      = 16;
    localparam int ACC_W      = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 39;

    // datapath widths
    localparam int MUL_W     = 25;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int EDT_W     = ERR_W + DT_W;
    localparam int ACC_SPLIT = 20;
    localparam int HI_W      = ILIM_W - ACC_SPLIT;
    localparam int LO_PROD_W = GAIN_W + ACC_SPLIT;
    localparam int HI_PROD_W = GAIN_W + HI_W;
    localparam int MAG_W     = 64;
    localparam int ITERM_W   = 51;
    localparam int SUM_W     = 52;
    localparam int FRAC_W    = 16;
    localparam int RAW_W     = SUM_W - FRAC_W;

    localparam logic [MAG_W-1:0] ITERM_CAP = 64'h0002_0000_0000_0000;
    localparam logic [SUM_W-1:0] ROUND_HALF = 52'h0_0000_0000_8000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_ZONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT   = 3'd5;

    localparam logic [ZONE_W-1:0] ZONE_RESET = 23'h7F_FFFF;
    localparam logic [OLIM_W-1:0] OLIM_RESET = 15'h7FFF;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [ZONE_W-1:0] integ_zone;
        logic [ILIM_W-1:0] integ_limit;
        logic [OLIM_W-1:0] out_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } t_mul_op;

endpackage

FILE: rtl/core/pidz_in_if.sv
`timescale 1ns / 1ps

interface pidz_in_if import pidz_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] heading_error;
    logic [DT_W-1:0]         step_time_ms;
    logic signed [YAW_W-1:0] yaw_rate;
    logic                    clear_integral;

    modport source (
        output valid, heading_error, step_time_ms, yaw_rate, clear_integral,
        input  ready
    );
    modport sink (
        input  valid, heading_error, step_time_ms, yaw_rate, clear_integral,
        output ready
    );
endinterface

FILE: rtl/core/pidz_out_if.sv
`timescale 1ns / 1ps

interface pidz_out_if import pidz_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] rate_command;
    logic                    saturated;

    modport source (
        output valid, rate_command, saturated,
        input  ready
    );
    modport sink (
        input  valid, rate_command, saturated,
        output ready
    );
endinterface

FILE: rtl/core/pidz_mul.sv
`timescale 1ns / 1ps

// Shared signed 25x25 multiplier with registered product.
module pidz_mul import pidz_pkg::*; (
    input  logic                     i_clk,
    input  t_mul_op                  i_op,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op.a * i_op.b;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/core/pidz_core.sv
`timescale 1ns / 1ps
`include "pid_integral_zone_antiwindup_defines.svh"

module pidz_core import pidz_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    pidz_in_if.sink         i_req,
    pidz_out_if.source      o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_ED, S_SUM, S_CLAMP, S_ABS, S_LO, S_HI, S_MAG, S_CAP, S_SUM2, S_EVAL
    } t_state;

    t_state                   r_state;
    logic signed [ERR_W-1:0]  r_err;
    logic [DT_W-1:0]          r_dt;
    logic signed [YAW_W-1:0]  r_yaw;
    logic signed [ACC_W-1:0]  r_old;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_inzone;
    logic signed [ACC_W:0]    r_n;
    logic signed [SUM_W-1:0]  r_pd;
    logic [ILIM_W-1:0]        r_abs;
    logic                     r_neg;
    logic [LO_PROD_W-1:0]     r_lo;
    logic [MAG_W-1:0]         r_mag;
    logic signed [ITERM_W-1:0] r_iterm;
    logic signed [SUM_W-1:0]  r_s;
    logic                     r_undone;
    logic                     r_out_valid;
    logic signed [CMD_W-1:0]  r_cmd;
    logic                     r_sat;

    t_mul_op                  mul_op;
    logic signed [PROD_W-1:0] prod;

    logic [ERR_W-1:0]          err_abs;
    logic signed [ACC_W:0]     ilim_pos;
    logic signed [ACC_W:0]     ilim_neg;
    logic signed [ACC_W:0]     n_clamped;
    logic signed [ACC_W-1:0]   acc_neg;
    logic [ITERM_W-1:0]        mag_capped;
    logic signed [ITERM_W-1:0] cap_s;
    logic [SUM_W-1:0]          s_round;
    logic signed [RAW_W-1:0]   raw;
    logic signed [RAW_W-1:0]   lim_pos;
    logic signed [RAW_W-1:0]   lim_neg;
    logic signed [RAW_W-1:0]   cmd_full;
    logic                      sat_now;
    logic                      undo_now;

    pidz_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod)
    );

    // operand select for the shared multiplier
    always_comb begin
        mul_op = '0;
        case (r_state)
            S_ED: begin
                mul_op.a = MUL_W'(r_err);
                mul_op.b = MUL_W'(r_dt);
            end
            S_SUM: begin
                mul_op.a = MUL_W'(r_err);
                mul_op.b = MUL_W'(i_cfg.prop_gain);
            end
            S_CLAMP: begin
                mul_op.a = MUL_W'(r_yaw);
                mul_op.b = MUL_W'(i_cfg.deriv_gain);
            end
            S_LO: begin
                mul_op.a = MUL_W'(r_abs[ACC_SPLIT-1:0]);
                mul_op.b = MUL_W'(i_cfg.integ_gain);
            end
            S_HI: begin
                mul_op.a = MUL_W'(r_abs[ILIM_W-1:ACC_SPLIT]);
                mul_op.b = MUL_W'(i_cfg.integ_gain);
            end
            default: begin
                mul_op = '0;
            end
        endcase
    end

    always_comb begin
        err_abs  = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
        ilim_pos = $signed({2'b00, i_cfg.integ_limit});
        ilim_neg = -ilim_pos;
        if (r_n > ilim_pos) begin
            n_clamped = ilim_pos;
        end else if (r_n < ilim_neg) begin
            n_clamped = ilim_neg;
        end else begin
            n_clamped = r_n;
        end
        acc_neg = -r_acc;

        mag_capped = (r_mag > ITERM_CAP) ? ITERM_CAP[ITERM_W-1:0] : r_mag[ITERM_W-1:0];
        cap_s      = $signed(mag_capped);

        // round half up, then drop the Q16 fraction
        s_round = r_s + ROUND_HALF;
        raw     = $signed(s_round[SUM_W-1:FRAC_W]);
        lim_pos = $signed({{(RAW_W-OLIM_W){1'b0}}, i_cfg.out_limit});
        lim_neg = -lim_pos;
        sat_now = (raw > lim_pos) || (raw < lim_neg);
        // saturated in the direction of the error: sat implies raw != 0
        undo_now = sat_now && (r_err != '0) && (raw[RAW_W-1] == r_err[ERR_W-1]) && !r_undone;
        if (raw > lim_pos) begin
            cmd_full = lim_pos;
        end else if (raw < lim_neg) begin
            cmd_full = lim_neg;
        end else begin
            cmd_full = raw;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.rate_command = r_cmd;
    assign o_rsp.saturated    = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_undone    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EVAL) && !undo_now && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_err    <= i_req.heading_error;
                        r_dt     <= i_req.step_time_ms;
                        r_yaw    <= i_req.yaw_rate;
                        r_old    <= i_req.clear_integral ? '0 : r_acc;
                        r_undone <= 1'b0;
                        r_state  <= S_ED;
                    end
                end
                S_ED: begin
                    r_inzone <= ({1'b0, i_cfg.integ_zone} >= err_abs);
                    r_state  <= S_SUM;
                end
                S_SUM: begin
                    r_n     <= (ACC_W+1)'(r_old) + (ACC_W+1)'($signed(prod[EDT_W-1:0]));
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_acc   <= r_inzone ? ACC_W'(n_clamped) : '0;
                    r_pd    <= SUM_W'(prod);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    // product holds the rate term only on the first pass
                    if (!r_undone) begin
                        r_pd <= r_pd - SUM_W'(prod);
                    end
                    r_abs   <= r_acc[ACC_W-1] ? acc_neg[ILIM_W-1:0] : r_acc[ILIM_W-1:0];
                    r_neg   <= r_acc[ACC_W-1];
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_lo    <= prod[LO_PROD_W-1:0];
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_mag   <= MAG_W'({prod[HI_PROD_W-1:0], {ACC_SPLIT{1'b0}}}) + MAG_W'(r_lo);
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_iterm <= r_neg ? -cap_s : cap_s;
                    r_state <= S_SUM2;
                end
                S_SUM2: begin
                    r_s     <= r_pd + SUM_W'(r_iterm);
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (undo_now) begin
                        r_acc    <= r_old;
                        r_undone <= 1'b1;
                        r_state  <= S_ABS;
                    end else if (!r_out_valid || o_rsp.ready) begin
                        r_cmd       <= cmd_full[CMD_W-1:0];
                        r_sat       <= sat_now;
                        r_undone    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PIDZ_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == S_ED)
    `PIDZ_ASSERT_IMPL(a_idle_no_undo, i_clk, i_rst_n, r_state == S_IDLE, !r_undone)
    `PIDZ_ASSERT_NEXT(a_undo_once, i_clk, i_rst_n, (r_state == S_EVAL) && r_undone, (r_state == S_IDLE) || (r_state == S_EVAL))
    `PIDZ_ASSERT_IMPL(a_undo_restores, i_clk, i_rst_n, (r_state == S_ABS) && r_undone, r_acc == r_old)

endmodule

FILE: rtl/core/pid_integral_zone_antiwindup.sv
// Heading-hold PID controller with integral zone and anti-windup.
// Channels: i_req carries one control tick (heading error, step time, yaw rate,
// clear flag); o_rsp carries the clamped rate command and the saturation flag.
// Both use valid/ready; a request moves when valid and ready are high at a clock edge.
// Configuration: i_cfg_we with i_cfg_idx and i_cfg_data writes one gain or limit
// register per cycle; write only while no request is in flight.
// The result is registered once the sequencer has stepped through its states; when
// the output saturates in the direction of the error, the integral step is
// rolled back and the command recomputed before the result is registered.
// A request is taken only while the block is idle; every product goes through a single
// shared 25x25 multiplier stepped by the sequencer, five products per pass and two
// more when the integral step is rolled back.
// A new request is taken as soon as the previous result sits in the output
// register; if the receiver stalls, the block holds the finished result and waits
// in its final step until the output register frees up.
// Reset (synchronous, active low) zeroes the integral and the gains, opens the
// integral zone and the output limit fully, and drops any pending result.
`timescale 1ns / 1ps

module pid_integral_zone_antiwindup import pidz_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pidz_in_if.sink               i_req,
    pidz_out_if.source            o_rsp
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= '0;
            r_cfg.integ_gain  <= '0;
            r_cfg.deriv_gain  <= '0;
            r_cfg.integ_zone  <= ZONE_RESET;
            r_cfg.integ_limit <= '0;
            r_cfg.out_limit   <= OLIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  r_cfg.deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_ZONE:  r_cfg.integ_zone  <= i_cfg_data[ZONE_W-1:0];
                CFG_INTEG_LIMIT: r_cfg.integ_limit <= i_cfg_data[ILIM_W-1:0];
                CFG_OUT_LIMIT:   r_cfg.out_limit   <= i_cfg_data[OLIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pidz_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule
